FILE: src/hwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hwm_pkg;

	// Operation codes carried on the opcode field; code 3 has no meaning.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_MEDIAN = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_MAX_VALUE   = 1'b0;
	localparam logic CFG_WINDOW_SIDE = 1'b1;

	localparam int unsigned BIN_W = 13;
	localparam logic [BIN_W-1:0] BIN_LIMIT = 13'd8191;

	localparam logic [7:0] MAX_VALUE_RST   = 8'd255;
	localparam logic [6:0] WINDOW_SIDE_RST = 7'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SCAN,
		ST_DONE
	} hwm_state_t;

endpackage

`default_nettype wire

FILE: src/histogram_window_median.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     opcode[1:0], sample_value[7:0]
// output    out_valid / out_ready   median[7:0]
// config    cfg_we                  cfg_index[0], cfg_data[7:0]
//
// After reset a clearing pass zeroes every bin of the memory in turn, with in_ready low.
// An add or remove beat passes through accept, memory read and saturating write back.
// A median beat searches the bins from bin 0 up to the bin at which the search ends (at most
// min(max_value, VALUE_BINS-1)): one bin per cycle passes the single adder and compare.
// The result sits in an output register; a new beat is accepted while it waits, and a
// later median that finds the register still full holds until out_ready frees it.

module histogram_window_median #(
	parameter int unsigned VALUE_BINS      = 256,
	parameter int unsigned MAX_WINDOW_SIDE = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] sample_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      median,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int unsigned IDX_W    = $clog2(VALUE_BINS);
	localparam int unsigned CMP_W    = ((IDX_W > 8) ? IDX_W : 8) + 1;
	localparam int unsigned SIDE_W   = $clog2(MAX_WINDOW_SIDE + 1);
	localparam int unsigned CW       = (SIDE_W > 7) ? SIDE_W : 7;
	localparam int unsigned MAX_RANK = MAX_WINDOW_SIDE * MAX_WINDOW_SIDE / 2 + 1;
	localparam int unsigned SUM_W    = $clog2(MAX_RANK + 8192);
	localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(VALUE_BINS - 1);

	hwm_pkg::hwm_state_t state_q, state_d;

	logic [7:0]              max_value_q;
	logic [6:0]              window_side_q;
	logic [hwm_pkg::BIN_W-1:0] bin_mem_q [VALUE_BINS];
	logic [hwm_pkg::BIN_W-1:0] rd_data_q;
	logic [IDX_W-1:0]        clr_q;
	logic [IDX_W-1:0]        idx_q;
	logic [1:0]              op_q;
	logic [IDX_W-1:0]        addr_q;
	logic [IDX_W-1:0]        top_q;
	logic [SUM_W-1:0]        rank_q;
	logic [SUM_W-1:0]        sum_q;
	logic [7:0]              res_q;
	logic [7:0]              median_q;
	logic                    out_valid_q;
	logic                    dv_s1;
	logic [IDX_W-1:0]        didx_s1;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_wa;
	logic [IDX_W-1:0]        mem_ra;
	logic [hwm_pkg::BIN_W-1:0] mem_wd;
	logic [hwm_pkg::BIN_W-1:0] upd_val;
	logic [SUM_W-1:0]        sum_next;
	logic                    rank_hit;
	logic                    scan_end;
	logic                    load_out;
	logic                    in_range;
	logic                    accept;
	logic [CW-1:0]           side_ext;
	logic [CW-1:0]           side_c;
	logic [2*CW-1:0]         side_sq;
	logic [IDX_W-1:0]        top_c;

	assign accept   = in_valid & in_ready;
	assign in_range = CMP_W'(sample_value) < CMP_W'(VALUE_BINS);

	// Rank and search bound are fixed per median from the configuration.
	assign side_ext = CW'(window_side_q);
	assign side_c   = (side_ext > CW'(MAX_WINDOW_SIDE)) ? CW'(MAX_WINDOW_SIDE) : side_ext;
	assign side_sq  = side_c * side_c;
	assign top_c    = (CMP_W'(max_value_q) > CMP_W'(VALUE_BINS - 1)) ? LAST_BIN
		: IDX_W'(max_value_q);

	always_comb begin
		if (op_q == hwm_pkg::OP_ADD) begin
			upd_val = (rd_data_q < hwm_pkg::BIN_LIMIT) ? rd_data_q + 1'b1 : rd_data_q;
		end else begin
			upd_val = (rd_data_q != '0) ? rd_data_q - 1'b1 : rd_data_q;
		end
	end

	// The running sum stays below the rank while scanning, so it never overflows.
	assign sum_next = sum_q + SUM_W'(rd_data_q);
	assign rank_hit = sum_next >= rank_q;
	assign scan_end = dv_s1 & (rank_hit | (didx_s1 == top_q));

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = idx_q;
		mem_wd   = upd_val;
		mem_ra   = idx_q;
		load_out = 1'b0;
		case (state_q)
			hwm_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
				if (clr_q == LAST_BIN) begin
					state_d = hwm_pkg::ST_IDLE;
				end
			end
			hwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (opcode)
						hwm_pkg::OP_ADD, hwm_pkg::OP_REMOVE: begin
							if (in_range) begin
								state_d = hwm_pkg::ST_UPD_RD;
							end
						end
						hwm_pkg::OP_MEDIAN: begin
							state_d = hwm_pkg::ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			hwm_pkg::ST_UPD_RD: begin
				state_d = hwm_pkg::ST_UPD_WR;
			end
			hwm_pkg::ST_UPD_WR: begin
				mem_we  = 1'b1;
				state_d = hwm_pkg::ST_IDLE;
			end
			hwm_pkg::ST_SCAN: begin
				mem_ra = addr_q;
				if (scan_end) begin
					state_d = hwm_pkg::ST_DONE;
				end
			end
			hwm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = hwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hwm_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hwm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q   <= hwm_pkg::MAX_VALUE_RST;
			window_side_q <= hwm_pkg::WINDOW_SIDE_RST;
		end else if (cfg_we) begin
			if (cfg_index == hwm_pkg::CFG_MAX_VALUE) begin
				max_value_q <= cfg_data;
			end else begin
				window_side_q <= cfg_data[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= bin_mem_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			dv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == hwm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == hwm_pkg::ST_SCAN) begin
				dv_s1 <= 1'b1;
			end else begin
				dv_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			idx_q  <= IDX_W'(sample_value);
			rank_q <= SUM_W'((side_sq >> 1) + 1'b1);
			top_q  <= top_c;
			sum_q  <= '0;
			addr_q <= '0;
		end
		if (state_q == hwm_pkg::ST_SCAN) begin
			addr_q  <= addr_q + 1'b1;
			didx_s1 <= addr_q;
			if (dv_s1) begin
				sum_q <= sum_next;
				if (rank_hit) begin
					res_q <= 8'(CMP_W'(didx_s1));
				end else begin
					res_q <= '0;
				end
			end
		end
		if (load_out) begin
			median_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

	// A result appears only after a finished search.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == hwm_pkg::ST_DONE)
		else $error("result raised without a finished search");

	// The search never looks past its bound.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwm_pkg::ST_SCAN && dv_s1) |-> didx_s1 <= top_q)
		else $error("median search passed its bound");

	// While searching the running sum has not yet reached the rank.
	a_sum_below_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwm_pkg::ST_SCAN) |-> sum_q < rank_q)
		else $error("search continued after reaching the rank");

	// A read-modify-write always writes back in the next cycle.
	a_upd_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hwm_pkg::ST_UPD_RD) |=> (state_q == hwm_pkg::ST_UPD_WR && mem_we))
		else $error("bin update lost its write back");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned BINS = 256;
	localparam int unsigned MAX_SIDE = 64;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned TAIL_CYCLES = 300;
	localparam int unsigned DEEP_BEATS = 100;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = hwm_pkg::OP_ADD;
	logic [7:0] sample_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] median;
	logic cfg_we = 1'b0;
	logic cfg_index = hwm_pkg::CFG_MAX_VALUE;
	logic [7:0] cfg_data = '0;

	logic [hwm_pkg::BIN_W-1:0] bin_counts [BINS];
	logic [7:0] max_value_reg;
	logic [6:0] window_side_reg;
	logic [7:0] expected_medians [$];
	logic [7:0] pixel_window [$];
	logic [7:0] want_median;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	histogram_window_median DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.sample_value(sample_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median(median),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] predict_median();
		int unsigned side;
		int unsigned rank;
		int unsigned running;
		side = (window_side_reg > MAX_SIDE) ? MAX_SIDE : window_side_reg;
		rank = side * side / 2 + 1;
		running = 0;
		for (int v = 0; v <= max_value_reg; v++) begin
			running += bin_counts[v];
			if (running >= rank)
				return v[7:0];
		end
		return 8'd0;
	endfunction

	function automatic void update_histogram(logic [1:0] op, logic [7:0] val);
		case (op)
			hwm_pkg::OP_ADD: begin
				if (bin_counts[val] != hwm_pkg::BIN_LIMIT)
					bin_counts[val] = bin_counts[val] + 1'b1;
			end
			hwm_pkg::OP_REMOVE: begin
				if (bin_counts[val] != '0)
					bin_counts[val] = bin_counts[val] - 1'b1;
			end
			hwm_pkg::OP_MEDIAN: begin
				expected_medians.push_back(predict_median());
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// The histogram is updated at the edge where the beat is accepted, so each
	// median report sees exactly the beats that went in ahead of it.
	task automatic send_beat(logic [1:0] op, logic [7:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sample_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		update_histogram(op, val);
	endtask

	// Add and remove beats give no result, so after the last median has come
	// back the bench waits out a settling time before the block is taken as idle.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_medians.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		while (!in_ready)
			@(negedge clk);
	endtask

	task automatic write_config(logic idx, logic [7:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == hwm_pkg::CFG_MAX_VALUE)
			max_value_reg = data;
		else
			window_side_reg = data[6:0];
	endtask

	task automatic test_reset_state();
		send_beat(hwm_pkg::OP_MEDIAN, 8'hFF);
		send_beat(hwm_pkg::OP_REMOVE, 8'h00);
		send_beat(OP_UNUSED, 8'hFF);
		repeat (3)
			send_beat(hwm_pkg::OP_ADD, 8'h00);
		repeat (2)
			send_beat(hwm_pkg::OP_ADD, 8'hFF);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		send_beat(hwm_pkg::OP_REMOVE, 8'hFF);
		send_beat(hwm_pkg::OP_MEDIAN, 8'hAA);
		send_beat(hwm_pkg::OP_ADD, 8'hAA);
		send_beat(hwm_pkg::OP_ADD, 8'h55);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h55);
	endtask

	task automatic test_config_extremes();
		write_config(hwm_pkg::CFG_MAX_VALUE, 8'd0);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		write_config(hwm_pkg::CFG_WINDOW_SIDE, 8'd0);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		repeat (3)
			send_beat(hwm_pkg::OP_REMOVE, 8'h00);
		write_config(hwm_pkg::CFG_MAX_VALUE, 8'h54);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		write_config(hwm_pkg::CFG_MAX_VALUE, 8'h55);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		write_config(hwm_pkg::CFG_WINDOW_SIDE, 8'd127);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		write_config(hwm_pkg::CFG_WINDOW_SIDE, 8'd64);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
		write_config(hwm_pkg::CFG_WINDOW_SIDE, 8'd2);
		write_config(hwm_pkg::CFG_MAX_VALUE, 8'd255);
		send_beat(hwm_pkg::OP_MEDIAN, 8'h00);
	endtask

	// Piles many samples into one bin and then removes past empty, with a
	// window large enough that only the deep bin can reach the rank.
	task automatic test_bin_saturation();
		write_config(hwm_pkg::CFG_WINDOW_SIDE, 8'd11);
		repeat (DEEP_BEATS)
			send_beat(hwm_pkg::OP_ADD, 8'd200);
		send_beat(hwm_pkg::OP_MEDIAN, 8'd0);
		write_config(hwm_pkg::CFG_MAX_VALUE, 8'd199);
		send_beat(hwm_pkg::OP_MEDIAN, 8'd0);
		write_config(hwm_pkg::CFG_MAX_VALUE, 8'd255);
		repeat (DEEP_BEATS + 1)
			send_beat(hwm_pkg::OP_REMOVE, 8'd200);
		send_beat(hwm_pkg::OP_MEDIAN, 8'd0);
	endtask

	// Mostly a sliding window: pixels enter until the window is full, then the
	// oldest leaves as new ones enter. A small share is stray traffic.
	task automatic test_random_traffic(int idle_pct, int stall_pct, int beats);
		int sent;
		int roll;
		int target;
		int base;
		logic [1:0] op;
		logic [7:0] pixel;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int half = 0; half < 2; half++) begin
			roll = $urandom_range(99);
			write_config(hwm_pkg::CFG_MAX_VALUE, (roll < 50) ? 8'd255 : (roll < 60) ? 8'd0 :
				8'($urandom));
			roll = $urandom_range(99);
			write_config(hwm_pkg::CFG_WINDOW_SIDE,
				(roll < 70) ? 8'($urandom_range(1, 5)) :
				(roll < 80) ? 8'd0 : (roll < 90) ? 8'd64 : 8'($urandom_range(6, 127)));
			target = (window_side_reg > 6) ? 40 : window_side_reg * window_side_reg;
			if (target == 0)
				target = 1;
			base = $urandom_range(0, 240);
			sent = 0;
			while (sent < beats / 2) begin
				roll = $urandom_range(99);
				if (roll < 22) begin
					send_beat(hwm_pkg::OP_MEDIAN, 8'($urandom));
					sent++;
				end else if (roll < 28) begin
					op = 2'($urandom);
					pixel = 8'($urandom);
					send_beat(op, pixel);
					if (op != OP_UNUSED)
						sent++;
				end else if (pixel_window.size() >= target && roll < 64) begin
					send_beat(hwm_pkg::OP_REMOVE, pixel_window.pop_front());
					sent++;
				end else begin
					pixel = $urandom_range(1) ? 8'($urandom) : 8'(base + $urandom_range(15));
					pixel_window.push_back(pixel);
					send_beat(hwm_pkg::OP_ADD, pixel);
					sent++;
				end
			end
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_medians.size() == 0) begin
				report_mismatch("unrequested median", 8'd0, median);
			end else begin
				want_median = expected_medians.pop_front();
				if (median !== want_median)
					report_mismatch("median", want_median, median);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < BINS; i++)
			bin_counts[i] = '0;
		max_value_reg = hwm_pkg::MAX_VALUE_RST;
		window_side_reg = hwm_pkg::WINDOW_SIDE_RST;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_config_extremes();
		test_bin_saturation();
		test_random_traffic(0, 0, 360);
		test_random_traffic(59, 0, 360);
		test_random_traffic(0, 59, 360);
		test_random_traffic(32, 32, 360);
		test_random_traffic(0, 0, 360);

		wait_idle();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/hwm_pkg.sv
src/histogram_window_median.sv
tb/testbench.sv
